/* design/ecv_pkg.sv */
`timescale 1ns / 1ps

package ecv_pkg;

  // Fixed port widths of the block.
  localparam int PROG_W = 17;
  localparam int SEL_W  = 3;
  localparam int OUT_W  = 18;

  // Table entries are Q30 values up to 2.0, held in 32 bits.
  localparam int TAB_W = 32;
  localparam longint unsigned Q30_ONE   = 64'd1 << 30;
  localparam longint unsigned LN2_Q30   = 64'd744261118;
  localparam longint unsigned TWOPI_Q30 = 64'd6746518852;

  // Curve selector codes.
  typedef enum logic [SEL_W-1:0] {
    SEL_LINEAR  = 3'd0,
    SEL_IN      = 3'd1,
    SEL_OUT     = 3'd2,
    SEL_INOUT   = 3'd3,
    SEL_BOUNCE  = 3'd4,
    SEL_ELASTIC = 3'd5,
    SEL_IDENT_A = 3'd6,
    SEL_IDENT_B = 3'd7
  } curve_t;

endpackage

/* design/ecv_poly.sv */
`timescale 1ns / 1ps

// Cubic ease curves, the bounce curve and the pass-through selectors.
// Seven register stages from t to res.
module ecv_poly #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   t,
  input  ecv_pkg::curve_t      sel,
  output logic [FRAC_BITS+1:0] res
);

  localparam int TW = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 7;
  localparam int D2W = 2 * DW;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam int DLY = 5;

  // Stage 1 signals.
  logic          half;
  logic [TW-1:0] cin;
  logic [RW-1:0] two_minus;
  logic [FRAC_BITS+4:0] t11;
  logic signed [DW-1:0] kone;
  logic [TW-1:0] base;
  logic signed [DW-1:0] d;

  logic [2*TW-1:0]      sq1;
  logic [TW-1:0]        cin1;
  logic signed [DW-1:0] d1;
  logic [TW-1:0]        base1;
  logic [TW-1:0]        t1;
  ecv_pkg::curve_t      sel1;
  logic                 half1;

  // Stage 2 signals.
  logic [2*TW:0]   sq_round;
  logic [2*TW-1:0] cp2;
  logic [D2W-1:0]  dsq2;
  logic [TW-1:0]   base2;
  logic [TW-1:0]   t2;
  ecv_pkg::curve_t sel2;
  logic            half2;

  // Stage 3 signals.
  logic [2*TW:0]  cube_sum;
  logic [TW-1:0]  cube;
  logic [D2W:0]   bnc_sum;
  logic [RW-1:0]  bounce;
  logic [RW-1:0]  res_next;
  logic [RW-1:0]  dly [0:DLY-1];

  // Operand of the cube and the bounce segment for this item.
  always_comb begin
    half = t < TW'(ONE / 2);
    two_minus = RW'(2 * ONE) - {t, 1'b0};
    unique case (sel)
      ecv_pkg::SEL_OUT:   cin = TW'(ONE) - t;
      ecv_pkg::SEL_INOUT: cin = half ? t : two_minus[TW-1:0];
      default:            cin = t;
    endcase
    t11 = (FRAC_BITS+5)'({t, 3'b000}) + (FRAC_BITS+5)'({t, 1'b0}) + (FRAC_BITS+5)'(t);
    priority if (t11 < (FRAC_BITS+5)'(4 * ONE)) begin
      kone = '0;
      base = '0;
    end else if (t11 < (FRAC_BITS+5)'(8 * ONE)) begin
      kone = DW'(12 * ONE);
      base = TW'(ONE * 3 / 4);
    end else if (t11 < (FRAC_BITS+5)'(10 * ONE)) begin
      kone = DW'(18 * ONE);
      base = TW'(ONE * 15 / 16);
    end else begin
      kone = DW'(21 * ONE);
      base = TW'(ONE * 63 / 64);
    end
    d = $signed(DW'({t11, 1'b0})) - kone;
  end

  always_ff @(posedge clk) begin
    sq1   <= (2*TW)'(cin) * (2*TW)'(cin);
    cin1  <= cin;
    d1    <= d;
    base1 <= base;
    t1    <= t;
    sel1  <= sel;
    half1 <= half;
  end

  // Second multiply of the cube and the bounce square.
  always_comb begin
    sq_round = ((2*TW+1)'(sq1) + (2*TW+1)'(ONE / 2)) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    cp2   <= (2*TW)'(sq_round[TW-1:0]) * (2*TW)'(cin1);
    dsq2  <= D2W'(d1 * d1);
    base2 <= base1;
    t2    <= t1;
    sel2  <= sel1;
    half2 <= half1;
  end

  // Rounding and the curve selected by the item.
  always_comb begin
    cube_sum = ((2*TW+1)'(cp2) + (2*TW+1)'(ONE / 2)) >> FRAC_BITS;
    cube = cube_sum[TW-1:0];
    bnc_sum = ((D2W+1)'(dsq2) + (D2W+1)'(32 * ONE)) >> (FRAC_BITS + 6);
    bounce = RW'(bnc_sum[RW-1:0]) + RW'(base2);
    unique case (sel2)
      ecv_pkg::SEL_IN:     res_next = RW'(cube);
      ecv_pkg::SEL_OUT:    res_next = RW'(ONE) - RW'(cube);
      ecv_pkg::SEL_INOUT:  res_next = half2 ? RW'({cube, 2'b00})
                                             : RW'(ONE) - ((RW'(cube) + RW'(1)) >> 1);
      ecv_pkg::SEL_BOUNCE: res_next = bounce;
      default:             res_next = RW'(t2);
    endcase
  end

  // Delay line that lines the result up with the elastic path.
  always_ff @(posedge clk) begin
    dly[0] <= res_next;
    for (int i = 1; i < DLY; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  assign res = dly[DLY-1];

endmodule

/* design/ecv_spring.sv */
`timescale 1ns / 1ps

// Elastic curve 2^(-10t) * sin((10t - 0.75) * 2pi/3) + 1 with interpolated
// tables. Seven register stages from t to res.
module ecv_spring #(
  parameter int FRAC_BITS       = 16,
  parameter int TABLE_ADDR_BITS = 8
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   t,
  output logic [FRAC_BITS+1:0] res
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int RW  = FRAC_BITS + 2;
  localparam int EW  = FRAC_BITS + 4;
  localparam int A   = TABLE_ADDR_BITS;
  localparam int SH  = 32 - A;
  localparam int SF  = 32 - FRAC_BITS;
  localparam int K3  = FRAC_BITS + 4;
  localparam int TAB_N = 1 << A;
  localparam int TBW = ecv_pkg::TAB_W;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam longint unsigned M3  = (64'd1 << K3) / 3 + 64'd1;
  localparam longint unsigned C1  = (64'd1 << SF) / 3;
  localparam longint unsigned C2  = (64'd1 << (SF + 1)) / 3;

  typedef logic [TBW-1:0] tab_arr_t [0:TAB_N];

  // Unsigned quotient by shift and subtract, used while building the tables.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(-y) in Q30 by its series.
  function automatic longint unsigned exp_neg_q30(input longint unsigned y);
    longint          sum;
    longint unsigned term;
    sum  = longint'(ecv_pkg::Q30_ONE);
    term = ecv_pkg::Q30_ONE;
    for (longint unsigned k = 1; k <= 14; k++) begin
      term = div_u64((term * y) >> 30, k);
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // sin(x) in Q30 by its series, clamped to [0, 1].
  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint          sum;
    longint unsigned term;
    sum  = longint'(x);
    term = x;
    for (longint unsigned k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = div_u64((term * x) >> 30, (2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ecv_pkg::Q30_ONE)) sum = longint'(ecv_pkg::Q30_ONE);
    return longint'(sum);
  endfunction

  // Builds the power table or the offset sine table.
  function automatic tab_arr_t build_tab(input bit want_sin);
    tab_arr_t        tab;
    longint unsigned y;
    longint unsigned j;
    longint unsigned qd;
    longint unsigned rq;
    longint unsigned aq;
    longint unsigned x;
    longint unsigned s;
    for (int i = 0; i <= TAB_N; i++) begin
      y  = (longint'(i) * ecv_pkg::LN2_Q30 + TAB_N / 2) >> A;
      j  = longint'(i) & (TAB_N - 1);
      qd = j >> (A - 2);
      rq = j & (TAB_N / 4 - 1);
      aq = qd[0] ? (TAB_N / 4 - rq) : rq;
      x  = (aq * ecv_pkg::TWOPI_Q30 + TAB_N / 2) >> A;
      s  = sin_q30(x);
      if (want_sin) tab[i] = TBW'((qd >= 2) ? ecv_pkg::Q30_ONE - s : ecv_pkg::Q30_ONE + s);
      else          tab[i] = TBW'(exp_neg_q30(y));
    end
    return tab;
  endfunction

  localparam tab_arr_t POW_TAB = build_tab(1'b0);
  localparam tab_arr_t SIN_TAB = build_tab(1'b1);

  // Stage 1 signals.
  logic [EW-1:0] e;
  logic [EW-1:0] ph;
  logic [RW-1:0] r;
  logic          zero1, one1;
  logic [3:0]    n1;
  logic [31:0]   fq1;
  logic [RW-1:0] r1;

  // Stage 2 signals.
  logic [RW+K3-1:0] r_m3;
  logic             zero2, one2;
  logic [3:0]       n2;
  logic [TBW-1:0]   pa2, pb2;
  logic [SH-1:0]    prem2;
  logic [FRAC_BITS-1:0] a3_2;
  logic [RW-1:0]    r2;

  // Stage 3 signals.
  logic [RW-1:0]  r_b;
  logic [31:0]    q;
  logic           zero3, one3;
  logic [3:0]     n3;
  logic [TBW-1:0] pa3;
  logic           pup3;
  logic [TBW+SH-1:0] pprod3;
  logic [TBW-1:0] sa3, sb3;
  logic [SH-1:0]  srem3;

  // Stage 4 signals.
  logic           zero4, one4;
  logic [3:0]     n4;
  logic [TBW-1:0] pw4;
  logic [TBW-1:0] sa4;
  logic           sup4;
  logic [TBW+SH-1:0] sprod4;

  // Stage 5 signals.
  logic [TBW-1:0] s5v;
  logic           zero5, one5, neg5;
  logic [3:0]     n5;
  logic [30:0]    pw5;
  logic [30:0]    mag5;

  // Stage 6 and output signals.
  logic           zero6, one6, neg6;
  logic [3:0]     n6;
  logic [61:0]    prod6;
  logic [6:0]     s2;
  logic [63:0]    rsum;
  logic [RW-1:0]  rr;
  logic [RW-1:0]  res_next;

  // Scale by ten, split into whole and fraction, and reduce the phase.
  always_comb begin
    e  = EW'({t, 3'b000}) + EW'({t, 1'b0});
    ph = e + EW'(9 * ONE / 4);
    priority if (ph >= EW'(12 * ONE)) r = RW'(ph - EW'(12 * ONE));
    else if (ph >= EW'(9 * ONE))      r = RW'(ph - EW'(9 * ONE));
    else if (ph >= EW'(6 * ONE))      r = RW'(ph - EW'(6 * ONE));
    else if (ph >= EW'(3 * ONE))      r = RW'(ph - EW'(3 * ONE));
    else                              r = RW'(ph);
  end

  always_ff @(posedge clk) begin
    zero1 <= (t == '0);
    one1  <= (t >= TW'(ONE));
    n1    <= e[EW-1:FRAC_BITS];
    fq1   <= {e[FRAC_BITS-1:0], SF'(0)};
    r1    <= r;
  end

  // Power table read and the divide by three of the phase.
  assign r_m3 = (RW+K3)'(r1) * (RW+K3)'(M3);

  always_ff @(posedge clk) begin
    zero2 <= zero1;
    one2  <= one1;
    n2    <= n1;
    pa2   <= POW_TAB[{1'b0, fq1[31:SH]}];
    pb2   <= POW_TAB[(A+1)'(fq1[31:SH]) + (A+1)'(1)];
    prem2 <= fq1[SH-1:0];
    a3_2  <= r_m3[K3 +: FRAC_BITS];
    r2    <= r1;
  end

  // Phase as a Q32 fraction, sine table read, power interpolation multiply.
  always_comb begin
    r_b = r2 - RW'(3 * (RW'(a3_2)));
    unique case (r_b[1:0])
      2'd1:    q = {a3_2, SF'(0)} + 32'(C1);
      2'd2:    q = {a3_2, SF'(0)} + 32'(C2);
      default: q = {a3_2, SF'(0)};
    endcase
  end

  always_ff @(posedge clk) begin
    zero3  <= zero2;
    one3   <= one2;
    n3     <= n2;
    pa3    <= pa2;
    pup3   <= pb2 >= pa2;
    pprod3 <= (TBW+SH)'((pb2 >= pa2) ? pb2 - pa2 : pa2 - pb2) * (TBW+SH)'(prem2);
    sa3    <= SIN_TAB[{1'b0, q[31:SH]}];
    sb3    <= SIN_TAB[(A+1)'(q[31:SH]) + (A+1)'(1)];
    srem3  <= q[SH-1:0];
  end

  // Power result and the sine interpolation multiply.
  always_ff @(posedge clk) begin
    zero4  <= zero3;
    one4   <= one3;
    n4     <= n3;
    pw4    <= pup3 ? pa3 + TBW'(pprod3 >> SH) : pa3 - TBW'(pprod3 >> SH);
    sa4    <= sa3;
    sup4   <= sb3 >= sa3;
    sprod4 <= (TBW+SH)'((sb3 >= sa3) ? sb3 - sa3 : sa3 - sb3) * (TBW+SH)'(srem3);
  end

  // Sine result with its offset taken off, as sign and magnitude.
  assign s5v = sup4 ? sa4 + TBW'(sprod4 >> SH) : sa4 - TBW'(sprod4 >> SH);

  always_ff @(posedge clk) begin
    zero5 <= zero4;
    one5  <= one4;
    n5    <= n4;
    pw5   <= pw4[30:0];
    neg5  <= s5v < TBW'(ecv_pkg::Q30_ONE);
    mag5  <= (s5v < TBW'(ecv_pkg::Q30_ONE)) ? 31'(TBW'(ecv_pkg::Q30_ONE) - s5v)
                                             : 31'(s5v - TBW'(ecv_pkg::Q30_ONE));
  end

  always_ff @(posedge clk) begin
    zero6 <= zero5;
    one6  <= one5;
    n6    <= n5;
    neg6  <= neg5;
    prod6 <= 62'(pw5) * 62'(mag5);
  end

  // Decay shift with rounding, then the endpoints and the floor at zero.
  always_comb begin
    s2   = 7'(60 - FRAC_BITS) + 7'(n6);
    rsum = (64'(prod6) + (64'd1 << (s2 - 7'd1))) >> s2;
    rr   = rsum[RW-1:0];
    priority if (zero6) res_next = '0;
    else if (one6)      res_next = RW'(ONE);
    else if (neg6)      res_next = (rr > RW'(ONE)) ? '0 : RW'(ONE) - rr;
    else                res_next = RW'(ONE) + rr;
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

/* design/easing_curve_evaluator.sv */
`timescale 1ns / 1ps
// An accepted item passes the input register and the valid stages; done rises from the output register.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the elastic path: two table reads, two interpolation
// multiplies and the 31 x 31 decay multiply, each registered.
// Reset (rst, synchronous) clears the valid bits; items in flight are dropped.
module easing_curve_evaluator #(
  parameter int FRAC_BITS       = 16,
  parameter int TABLE_ADDR_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ecv_pkg::PROG_W-1:0]   progress,
  input  logic [ecv_pkg::SEL_W-1:0]    req_type,
  output logic                         done,
  output logic [ecv_pkg::OUT_W-1:0]    eased_value
);

  localparam int TW = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 2;
  localparam int XW = (TW > ecv_pkg::PROG_W) ? TW : ecv_pkg::PROG_W;
  localparam int SW = (RW > ecv_pkg::OUT_W) ? RW : ecv_pkg::OUT_W;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam longint unsigned OUT_MAX = (64'd1 << ecv_pkg::OUT_W) - 64'd1;
  localparam longint unsigned LIM = (2 * ONE > OUT_MAX) ? OUT_MAX : 2 * ONE;
  localparam int DEPTH = 7;

  logic [XW-1:0]   prog_x;
  logic            v0;
  logic [TW-1:0]   t0;
  ecv_pkg::curve_t sel0;
  logic            vpipe [0:DEPTH-1];
  ecv_pkg::curve_t spipe [0:DEPTH-1];
  logic [RW-1:0]   poly_res;
  logic [RW-1:0]   spring_res;
  logic [SW-1:0]   res_x;
  logic [SW-1:0]   sat;

  assign busy = 1'b0;

  // Input register: progress saturates at one.
  assign prog_x = XW'(progress);

  always_ff @(posedge clk) begin
    t0   <= (prog_x > XW'(ONE)) ? TW'(ONE) : prog_x[TW-1:0];
    sel0 <= ecv_pkg::curve_t'(req_type);
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  ecv_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk (clk),
    .t   (t0),
    .sel (sel0),
    .res (poly_res)
  );

  ecv_spring #(.FRAC_BITS(FRAC_BITS), .TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_spring (
    .clk (clk),
    .t   (t0),
    .res (spring_res)
  );

  // Valid bits and selectors travel beside the curve units.
  always_ff @(posedge clk) begin
    spipe[0] <= sel0;
    for (int i = 1; i < DEPTH; i++) begin
      spipe[i] <= spipe[i-1];
    end
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        vpipe[i] <= 1'b0;
      end
    end else begin
      vpipe[0] <= v0;
      for (int i = 1; i < DEPTH; i++) begin
        vpipe[i] <= vpipe[i-1];
      end
    end
  end

  // Pick the unit, clamp to the output range and register the item.
  always_comb begin
    res_x = (spipe[DEPTH-1] == ecv_pkg::SEL_ELASTIC) ? SW'(spring_res) : SW'(poly_res);
    sat   = (res_x > SW'(LIM)) ? SW'(LIM) : res_x;
  end

  always_ff @(posedge clk) begin
    eased_value <= sat[ecv_pkg::OUT_W-1:0];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vpipe[DEPTH-1];
    end
  end

endmodule

/* design/ecv_checker.sv */
`timescale 1ns / 1ps

// Port-level checks of the evaluator.
module ecv_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [ecv_pkg::PROG_W-1:0] progress,
  input logic [ecv_pkg::SEL_W-1:0]  req_type,
  input logic                       done,
  input logic [ecv_pkg::OUT_W-1:0]  eased_value
);

  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam longint unsigned OUT_MAX = (64'd1 << ecv_pkg::OUT_W) - 64'd1;
  localparam longint unsigned LIM = (2 * ONE > OUT_MAX) ? OUT_MAX : 2 * ONE;

  // Every accepted item yields a strobe after the fixed latency.
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##9 done)
    else $error("accepted item gave no result");

  // No strobe without an accepted item.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##9 !done)
    else $error("result without an item");

  // Results stay within the clamp.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (64'(eased_value) <= LIM))
    else $error("result above range");

  // Identity selectors return the saturated progress.
  a_identity: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == ecv_pkg::SEL_IDENT_A || req_type == ecv_pkg::SEL_IDENT_B)
    |-> ##9 (64'(eased_value) == ((64'($past(progress, 9)) > ONE) ? ONE
                                  : 64'($past(progress, 9)))))
    else $error("identity result wrong");

endmodule

bind easing_curve_evaluator ecv_checker #(.FRAC_BITS(FRAC_BITS)) u_ecv_checker (.*);
